// ----- rtl/b64enc_pkg.sv -----
package b64enc_pkg;

   // standard alphabet, packed so that index 63 holds 'A'
   localparam logic [63:0][7:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam int MAX_CHARS = 4;

   // characters that one request produces, with the index of the last one
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [1:0]                last_idx;
      logic                      is_final;
   } entry_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      sextet_char = ALPHABET[6'd63 - v];
   endfunction

endpackage

// ----- rtl/b64enc_if.sv -----
interface b64enc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_final;

   modport source (output valid, output data_byte, output is_final, input ready);
   modport sink (input valid, input data_byte, input is_final, output ready);
endinterface

interface b64enc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;
   logic       message_end;

   modport source (output valid, output out_char, output run_last, output message_end,
                   input ready);
   modport sink (input valid, input out_char, input run_last, input message_end,
                 output ready);
endinterface

// ----- rtl/b64enc_front.sv -----
module b64enc_front (
   input  logic                  clock,
   input  logic                  reset,
   b64enc_req_if.sink            req_ch,
   input  logic                  q_full,
   output logic                  push,
   output b64enc_pkg::entry_type push_entry
);
   import b64enc_pkg::*;

   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] b;
   logic       fin;

   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;
   assign b            = req_ch.data_byte;
   assign fin          = req_ch.is_final;

   always_comb begin
      push_entry.chars    = {MAX_CHARS{PAD_CHAR}};
      push_entry.is_final = fin;
      push_entry.last_idx = 2'd0;
      phase_in            = PHASE_0;
      left_in             = 4'd0;
      unique case (phase_ff)
         PHASE_1: begin
            push_entry.chars[0] = sextet_char({left_ff[1:0], b[7:4]});
            push_entry.chars[1] = sextet_char({b[3:0], 2'b00});
            push_entry.last_idx = fin ? 2'd2 : 2'd0;
            phase_in            = PHASE_2;
            left_in             = b[3:0];
         end
         PHASE_2: begin
            push_entry.chars[0] = sextet_char({left_ff, b[7:6]});
            push_entry.chars[1] = sextet_char(b[5:0]);
            push_entry.last_idx = 2'd1;
         end
         // the unused phase code behaves as phase 0
         default: begin
            push_entry.chars[0] = sextet_char(b[7:2]);
            push_entry.chars[1] = sextet_char({b[1:0], 4'b0000});
            push_entry.last_idx = fin ? 2'd3 : 2'd0;
            phase_in            = PHASE_1;
            left_in             = {2'b00, b[1:0]};
         end
      endcase
      if (fin) begin
         phase_in = PHASE_0;
         left_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         left_ff  <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ----- rtl/b64enc_queue.sv -----
module b64enc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64enc_pkg::entry_type push_entry,
   output logic                  full,
   output logic                  pop_valid,
   output b64enc_pkg::entry_type pop_entry,
   input  logic                  pop
);
   import b64enc_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/b64enc_back.sv -----
module b64enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  b64enc_pkg::entry_type q_entry,
   output logic                  pop,
   b64enc_rsp_if.source          rsp_ch
);
   import b64enc_pkg::*;

   entry_type  cur_ff;
   logic       cur_valid_ff;
   logic [1:0] idx_ff;
   logic       at_last;
   logic       fire;

   assign at_last = (idx_ff == cur_ff.last_idx);
   assign fire    = rsp_ch.valid && rsp_ch.ready;
   assign pop     = q_valid && (!cur_valid_ff || (fire && at_last));

   assign rsp_ch.valid       = cur_valid_ff;
   assign rsp_ch.out_char    = cur_ff.chars[idx_ff];
   assign rsp_ch.run_last    = at_last;
   assign rsp_ch.message_end = at_last && cur_ff.is_final;

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= 2'd0;
      end else if (fire) begin
         if (at_last) begin
            cur_valid_ff <= 1'b0;
            idx_ff       <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.message_end) |-> rsp_ch.run_last)
      else $error("message end without run end");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (idx_ff <= cur_ff.last_idx))
      else $error("character index past last character");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (fire && !at_last) |=> (rsp_ch.valid && idx_ff == $past(idx_ff) + 2'd1))
      else $error("run dropped before its last character");

   a_pop_only_free: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && !fire) |-> !pop)
      else $error("entry loaded over a pending run");

endmodule

// ----- rtl/base64_stream_encoder.sv -----
// base64 stream encoder, standard alphabet with '=' padding
//
// req_ch carries one message byte per request with is_final on the last
// byte of a message. rsp_ch carries one ascii character per transfer;
// run_last marks the last character for a byte, message_end the last
// character of the whole encoded message.
// a byte produces one character (group positions 0 and 1) or two
// (position 2); a final byte flushes and pads to four characters, so it
// produces two to four.
// the front accepts a byte whenever the queue has room and
// builds all of its characters at once. the back sends one character per
// cycle while rsp_ch is ready, so rsp_ch bounds the rate. with an empty
// queue a byte is registered in the queue and then in the output stage
// before its first character is sent.
// reset empties the queue and the output stage and returns the group
// position to the start of a message.
// when rsp_ch stalls the current character holds, the queue fills, and
// req_ch.ready drops once QUEUE_DEPTH byte entries are waiting.
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   b64enc_req_if.sink   req_ch,
   b64enc_rsp_if.source rsp_ch
);
   import b64enc_pkg::*;

   logic      q_full;
   logic      push;
   logic      pop;
   logic      q_valid;
   entry_type push_entry;
   entry_type q_entry;

   b64enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry),
      .pop        (pop)
   );

   b64enc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ----- sim/tb_base64_stream_encoder.sv -----
`timescale 1ns / 1ps

module tb_base64_stream_encoder;

   localparam logic [1:0] GROUP_POS0 = 2'd0;
   localparam logic [1:0] GROUP_POS1 = 2'd1;
   localparam logic [1:0] GROUP_POS2 = 2'd2;

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_PLUS    = 8'h2B;
   localparam logic [7:0] ASCII_SLASH   = 8'h2F;

   localparam int RANDOM_BYTES = 400;
   localparam int CALM_TAIL    = 40;

   typedef struct {
      logic [7:0] data_byte;
      logic       is_final;
      int         gap;
      bit         drain;
   } byte_req_type;

   typedef struct {
      logic [7:0] out_char;
      logic       run_last;
      logic       message_end;
   } enc_char_type;

   logic clock;
   logic reset;

   b64enc_req_if req_ch ();
   b64enc_rsp_if rsp_ch ();

   base64_stream_encoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   byte_req_type  pending_reqs [$];
   enc_char_type  expected_chars [$];
   byte_req_type  cur_req;
   enc_char_type  want_char;

   logic [1:0] group_phase;
   logic [3:0] leftover_bits;

   bit holding;
   bit calm_tail;
   int gap_left;
   int stall_left;
   int accepted_count;
   int total_reqs;
   int errors;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] v8;
      v8 = {2'b00, v};
      if (v8 < 8'd26) return ASCII_UPPER_A + v8;
      if (v8 < 8'd52) return ASCII_LOWER_A + (v8 - 8'd26);
      if (v8 < 8'd62) return ASCII_ZERO + (v8 - 8'd52);
      if (v8 == 8'd62) return ASCII_PLUS;
      return ASCII_SLASH;
   endfunction

   // encoder state advance, pushes the characters one request produces
   task automatic predict_chars(input logic [7:0] b, input logic fin);
      logic [7:0]   chars [$];
      enc_char_type ec;
      case (group_phase)
         GROUP_POS1: begin
            chars.push_back(b64_char({leftover_bits[1:0], b[7:4]}));
            leftover_bits = b[3:0];
            group_phase   = GROUP_POS2;
            if (fin) begin
               chars.push_back(b64_char({b[3:0], 2'b00}));
               chars.push_back(b64enc_pkg::PAD_CHAR);
            end
         end
         GROUP_POS2: begin
            chars.push_back(b64_char({leftover_bits, b[7:6]}));
            chars.push_back(b64_char(b[5:0]));
            leftover_bits = 4'd0;
            group_phase   = GROUP_POS0;
         end
         default: begin
            // position three is unreachable and behaves as the group start
            chars.push_back(b64_char(b[7:2]));
            leftover_bits = {2'b00, b[1:0]};
            group_phase   = GROUP_POS1;
            if (fin) begin
               chars.push_back(b64_char({b[1:0], 4'b0000}));
               chars.push_back(b64enc_pkg::PAD_CHAR);
               chars.push_back(b64enc_pkg::PAD_CHAR);
            end
         end
      endcase
      for (int i = 0; i < chars.size(); i++) begin
         ec.out_char    = chars[i];
         ec.run_last    = (i == chars.size() - 1);
         ec.message_end = fin && (i == chars.size() - 1);
         expected_chars.push_back(ec);
      end
      if (fin) begin
         group_phase   = GROUP_POS0;
         leftover_bits = 4'd0;
      end
   endtask

   task automatic add_req(input logic [7:0] b, input logic fin, input int gap, input bit drain);
      byte_req_type r;
      r.data_byte = b;
      r.is_final  = fin;
      r.gap       = gap;
      r.drain     = drain;
      pending_reqs.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         holding = 1'b0;
         gap_left = 0;
         group_phase = GROUP_POS0;
         leftover_bits = 4'd0;
      end else begin
         if (holding && req_ch.ready) begin
            predict_chars(cur_req.data_byte, cur_req.is_final);
            accepted_count++;
            holding = 1'b0;
            if (accepted_count >= total_reqs - CALM_TAIL) calm_tail = 1'b1;
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               if (!calm_tail && pending_reqs[0].gap > 0) begin
                  gap_left = pending_reqs[0].gap - 1;
                  pending_reqs[0].gap = 0;
               end else if (!pending_reqs[0].drain || expected_chars.size() == 0) begin
                  cur_req = pending_reqs.pop_front();
                  req_ch.data_byte <= cur_req.data_byte;
                  req_ch.is_final  <= cur_req.is_final;
                  holding = 1'b1;
               end
            end
         end
         req_ch.valid <= holding;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_chars.size() == 0) begin
               report($sformatf("unexpected char 0x%02h", rsp_ch.out_char));
            end else begin
               want_char = expected_chars.pop_front();
               if (rsp_ch.out_char !== want_char.out_char)
                  report($sformatf("out_char 0x%02h, wanted 0x%02h",
                                   rsp_ch.out_char, want_char.out_char));
               if (rsp_ch.run_last !== want_char.run_last)
                  report($sformatf("run_last %b, wanted %b",
                                   rsp_ch.run_last, want_char.run_last));
               if (rsp_ch.message_end !== want_char.message_end)
                  report($sformatf("message_end %b, wanted %b",
                                   rsp_ch.message_end, want_char.message_end));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int len;
      int sel;
      int gap;
      logic [7:0] b;

      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.is_final  = 1'b0;
      rsp_ch.ready     = 1'b0;
      holding          = 1'b0;
      calm_tail        = 1'b0;
      accepted_count   = 0;
      errors           = 0;
      total_reqs       = 1 << 30;

      // single-byte messages at the extremes: two sextets then double pad
      add_req(8'h00, 1'b1, 0, 1'b0);
      add_req(8'hFF, 1'b1, 0, 1'b0);
      // two-byte messages: final on group position one, single pad
      add_req(8'h00, 1'b0, 0, 1'b0);
      add_req(8'hFF, 1'b1, 0, 1'b0);
      add_req(8'hFF, 1'b0, 0, 1'b0);
      add_req(8'h00, 1'b1, 0, 1'b0);
      // full group, final on position two, no padding
      add_req(8'h4D, 1'b0, 0, 1'b0);
      add_req(8'h61, 1'b0, 0, 1'b0);
      add_req(8'h6E, 1'b1, 0, 1'b0);
      // the two top alphabet entries
      add_req(8'hFB, 1'b0, 0, 1'b0);
      add_req(8'hFF, 1'b0, 0, 1'b0);
      add_req(8'hBF, 1'b1, 0, 1'b0);
      // five bytes: group wraps, final on position one
      for (int i = 0; i < 5; i++) add_req(8'hFF, i == 4, 0, 1'b0);
      // four bytes: group wraps, final on position zero
      for (int i = 0; i < 4; i++) add_req(8'h00, i == 3, 0, 1'b0);

      // random messages
      while (pending_reqs.size() < 21 + RANDOM_BYTES) begin
         sel = $urandom_range(0, 9);
         if (sel < 7) len = $urandom_range(1, 6);
         else if (sel < 9) len = $urandom_range(7, 20);
         else len = $urandom_range(21, 48);
         for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 7);
            if (sel == 0) b = 8'h00;
            else if (sel == 1) b = 8'hFF;
            else b = 8'($urandom);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
            add_req(b, i == len - 1, gap, 1'b0);
         end
      end
      // hold the sender until the encoder has fully drained
      pending_reqs[21].drain = 1'b1;
      pending_reqs[pending_reqs.size() / 2].drain = 1'b1;
      total_reqs = pending_reqs.size();

      wait (accepted_count == total_reqs);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_chars.size() != 0)
         report($sformatf("%0d chars never arrived", expected_chars.size()));
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #500000;
      $display("timeout with %0d chars outstanding", expected_chars.size());
      $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/b64enc_pkg.sv
rtl/b64enc_if.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder.sv
sim/tb_base64_stream_encoder.sv
